/* rtl/bshlp_pkg.sv */
package bshlp_pkg;

  localparam int NUM_KEYS = 16;
  localparam int KEY_W = $clog2(NUM_KEYS);
  localparam int COUNT_W = 16;
  localparam int INTV_W = 8;
  localparam int OP_W = 2;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [OP_W-1:0] OP_SCAN  = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_FIRST = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INTERVAL  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WATCHED   = 2'd2;

  localparam logic [COUNT_W-1:0] THRESHOLD_RESET = 16'd40;
  localparam logic [INTV_W-1:0] INTERVAL_RESET = 8'd4;
  localparam logic [KEY_W-1:0] WATCHED_RESET = 4'd0;

  localparam logic [KEY_W-1:0] KEY_MAP [NUM_KEYS] = '{
    4'd14, 4'd0, 4'd1, 4'd2, 4'd7, 4'd6, 4'd5, 4'd8,
    4'd9, 4'd10, 4'd3, 4'd4, 4'd11, 4'd12, 4'd15, 4'd13
  };

  typedef struct packed {
    logic [COUNT_W-1:0] mark;
    logic armed;
    logic reported;
    logic [COUNT_W-1:0] count;
  } entry_t;

  function automatic logic [KEY_W-1:0] phys_of(input logic [KEY_W-1:0] logical);
    return KEY_MAP[logical];
  endfunction

  function automatic logic [KEY_W-1:0] slot_of_bit(input int i);
    logic [KEY_W-1:0] s;
    if (i <= 3) s = KEY_W'(i + 4);
    else if (i <= 7) s = KEY_W'(7 - i);
    else if (i <= 11) s = KEY_W'(i + 4);
    else s = KEY_W'(23 - i);
    return s;
  endfunction

  // Reorders the scan word so that bit s is the release bit of physical key s.
  function automatic logic [NUM_KEYS-1:0] released_by_slot(input logic [NUM_KEYS-1:0] word);
    logic [NUM_KEYS-1:0] rel;
    rel = '0;
    for (int i = 0; i < NUM_KEYS; i++) begin
      rel[slot_of_bit(i)] = word[NUM_KEYS-1-i];
    end
    return rel;
  endfunction

endpackage

/* rtl/bshlp_ram.sv */
module bshlp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/button_scan_hold_long_press_core.sv */
// Channel  Signals                                   Direction
// input    in_valid, in_stall, op, scan_word, button  in_stall driven here
// output   out_valid, out_stall, hold_count,          out_stall driven by sink
//          first_press, repeat_trigger
// config   cfg_we, cfg_index, cfg_data                write only
//
// A scan item has a start step, a sweep of the key-state memory that updates one key per
// cycle over all 16 keys, and a read and an update of the watched key. A query reads the
// entry of one key. The sweep rate is set by the single read port of the key-state memory.
// One input item is buffered, so the next item is taken while the current one is at work.
// Reset clears the control state and marks every key entry as zero.
// A stalled result holds the engine before it writes the next result.
module button_scan_hold_long_press_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [bshlp_pkg::OP_W-1:0]         op,
  input  logic [bshlp_pkg::NUM_KEYS-1:0]     scan_word,
  input  logic [bshlp_pkg::KEY_W-1:0]        button,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [bshlp_pkg::COUNT_W-1:0]      hold_count,
  output logic                               first_press,
  output logic                               repeat_trigger,
  input  logic                               cfg_we,
  input  logic [bshlp_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [bshlp_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import bshlp_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SWEEP  = 3'd1;
  localparam logic [2:0] S_CHK_RD = 3'd2;
  localparam logic [2:0] S_CHK    = 3'd3;
  localparam logic [2:0] S_QRY    = 3'd4;

  localparam logic [KEY_W-1:0] LAST_KEY = KEY_W'(NUM_KEYS - 1);

  logic [2:0] state, state_next;

  logic hv;
  logic [OP_W-1:0] h_op;
  logic [NUM_KEYS-1:0] h_word;
  logic [KEY_W-1:0] h_button;

  logic [OP_W-1:0] cur_op;
  logic [NUM_KEYS-1:0] rel;
  logic [KEY_W-1:0] key;
  logic [KEY_W-1:0] cnt, cnt_next;

  logic [COUNT_W-1:0] thr;
  logic [INTV_W-1:0] intv;
  logic [KEY_W-1:0] watched;

  logic [NUM_KEYS-1:0] vld;
  logic vld_rd;
  logic trig, trig_next;

  logic re, we;
  logic [KEY_W-1:0] raddr, waddr;
  entry_t wdata, rdata, rd_entry;

  logic take, out_free, o_load, o_first_next;
  logic [COUNT_W-1:0] diff;

  bshlp_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(NUM_KEYS)
  ) u_key_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign rd_entry = vld_rd ? rdata : '0;
  assign in_stall = hv;
  assign out_free = !out_valid || !out_stall;
  assign diff = rd_entry.count - rd_entry.mark;

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    trig_next = trig;
    re = 1'b0;
    raddr = cnt;
    we = 1'b0;
    waddr = cnt;
    wdata = rd_entry;
    take = 1'b0;
    o_load = 1'b0;
    o_first_next = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (hv) begin
          if (h_op == OP_SCAN) begin
            take = 1'b1;
            re = 1'b1;
            raddr = '0;
            cnt_next = '0;
            state_next = S_SWEEP;
          end else if (out_free) begin
            take = 1'b1;
            re = 1'b1;
            raddr = phys_of(h_button);
            state_next = S_QRY;
          end
        end
      end
      S_SWEEP: begin
        we = 1'b1;
        waddr = cnt;
        if (rel[cnt]) begin
          wdata.count = '0;
          wdata.reported = 1'b0;
          trig_next = 1'b0;
        end else if (rd_entry.count != COUNT_MAX) begin
          wdata.count = rd_entry.count + 1'b1;
        end
        if (cnt == LAST_KEY) begin
          state_next = S_CHK_RD;
        end else begin
          re = 1'b1;
          raddr = cnt + 1'b1;
          cnt_next = cnt + 1'b1;
        end
      end
      S_CHK_RD: begin
        if (out_free) begin
          re = 1'b1;
          raddr = key;
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        we = 1'b1;
        waddr = key;
        o_load = 1'b1;
        if (rd_entry.count == '0) begin
          wdata.armed = 1'b0;
          wdata.mark = '0;
        end else if (rd_entry.count > thr) begin
          if (!rd_entry.armed) begin
            wdata.armed = 1'b1;
            wdata.mark = rd_entry.count;
          end else if (rd_entry.count >= rd_entry.mark &&
                       diff >= COUNT_W'(intv)) begin
            trig_next = 1'b1;
            wdata.mark = rd_entry.count;
          end
        end
        state_next = S_IDLE;
      end
      S_QRY: begin
        waddr = key;
        o_load = 1'b1;
        if (cur_op == OP_FIRST && !rd_entry.reported && rd_entry.count != '0) begin
          we = 1'b1;
          wdata.reported = 1'b1;
          o_first_next = 1'b1;
        end
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      hv <= 1'b0;
      out_valid <= 1'b0;
      vld <= '0;
      vld_rd <= 1'b0;
      trig <= 1'b0;
      cnt <= '0;
      thr <= THRESHOLD_RESET;
      intv <= INTERVAL_RESET;
      watched <= WATCHED_RESET;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      trig <= trig_next;
      if (take) begin
        hv <= 1'b0;
      end else if (in_valid && !hv) begin
        hv <= 1'b1;
      end
      if (o_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      if (re) begin
        vld_rd <= vld[raddr];
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_THRESHOLD: thr <= cfg_data;
          REG_INTERVAL:  intv <= cfg_data[INTV_W-1:0];
          REG_WATCHED:   watched <= cfg_data[KEY_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !hv) begin
      h_op <= op;
      h_word <= scan_word;
      h_button <= button;
    end
    if (take) begin
      cur_op <= h_op;
      rel <= released_by_slot(h_word);
      key <= (h_op == OP_SCAN) ? phys_of(watched) : phys_of(h_button);
    end
    if (o_load) begin
      hold_count <= rd_entry.count;
      first_press <= o_first_next;
      repeat_trigger <= trig_next;
    end
  end

endmodule
